// File: design/avsadq_pkg.sv
`default_nettype none

package avsadq_pkg;

	localparam int TS_W     = 63;
	localparam int WIDE_W   = 64;
	localparam int FRAMES_W = 14;
	localparam int TAG_W    = 8;
	localparam int PAD_W    = 20;
	localparam int ACT_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 41;

	localparam int RATE_W   = 19;
	localparam int OFFS_W   = 41;
	localparam int WIN_W    = 30;
	localparam int MAXD_W   = 40;
	localparam int STALL_W  = 34;
	localparam int IDLE_W   = 34;

	// frames times one second in ns: 20 bits by 30 bits
	localparam int NSEC_W   = 30;
	localparam int PROD_W   = PAD_W + NSEC_W;
	localparam int DCNT_W   = $clog2(PROD_W + 1);
	localparam logic [NSEC_W-1:0] NS_PER_SEC = NSEC_W'(1000000000);

	localparam logic [RATE_W-1:0]  RST_DEV_RATE    = RATE_W'(48000);
	localparam logic [OFFS_W-1:0]  RST_SYNC_OFFSET = '0;
	localparam logic [WIN_W-1:0]   RST_SYNC_WINDOW = WIN_W'(75000000);
	localparam logic [MAXD_W-1:0]  RST_MAX_DIFF    = MAXD_W'(64'd5000000000);
	localparam logic [STALL_W-1:0] RST_VIDEO_STALL = STALL_W'(100000000);
	localparam logic [IDLE_W-1:0]  RST_IDLE_FLUSH  = IDLE_W'(1000000000);

	typedef enum logic [ACT_W-1:0] {
		ACT_PLAY   = 3'd0,
		ACT_DROP   = 3'd1,
		ACT_FLUSH  = 3'd2,
		ACT_REJECT = 3'd3,
		ACT_HOLD   = 3'd4
	} avsadq_action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEV_RATE    = 3'd0,
		CFG_SYNC_OFFSET = 3'd1,
		CFG_SYNC_WINDOW = 3'd2,
		CFG_MAX_DIFF    = 3'd3,
		CFG_VIDEO_STALL = 3'd4,
		CFG_IDLE_FLUSH  = 3'd5
	} avsadq_cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAP,
		ST_FLUSH,
		ST_ENQ,
		ST_DIV_F,
		ST_DIV_P,
		ST_WALK_DIFF,
		ST_WALK_MAG,
		ST_WALK_DEC
	} avsadq_state_t;

	typedef struct packed {
		logic             start;
		logic [PAD_W-1:0] frames;
	} avsadq_div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quo;
	} avsadq_div_rsp_t;

endpackage

`default_nettype wire

// File: design/avsadq_div.sv
`default_nettype none

// frames -> ns: one multiply on start, then restoring division, one bit a cycle
module avsadq_div import avsadq_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [RATE_W-1:0]     dev_rate,
	input  wire avsadq_div_req_t       req,
	output avsadq_div_rsp_t            rsp
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [RATE_W-1:0] rem_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] quo_q;

	logic [RATE_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, prod_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, dev_rate};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_q <= PROD_W'(req.frames) * PROD_W'(NS_PER_SEC);
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			prod_q <= {prod_q[PROD_W-2:0], 1'b0};
			rem_q  <= fits ? RATE_W'(trial - {1'b0, dev_rate}) : trial[RATE_W-1:0];
			quo_q  <= {quo_q[PROD_W-2:0], fits};
		end
	end

	// zero rate converts to zero
	assign rsp.done = done_q;
	assign rsp.quo  = (dev_rate == '0) ? '0 : quo_q;

endmodule

`default_nettype wire

// File: design/av_sync_audio_delay_queue.sv
`default_nettype none

// Channel | Direction | Handshake             | Payload
// in      | sink      | in_valid / in_ready   | audio_ts, frame_count, packet_tag,
//         |           |                       | pad_frames, video_ts, now_ns
// out     | source    | out_valid / out_ready | action, out_tag, out_ts, out_frames, last
// cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request at a time. Each request goes through intake and a gap check, a flush when
// due that emits each queued entry and then closes, queuing, the shared frame-to-ns
// divider (once for the packet, once for the padding), then the diff, magnitude and
// decision steps for each head examined. Each dropped entry adds another head
// examination, and the block waits whenever out_ready holds back a result.
// Reset clears control, config and tracker state; queue entries are not cleared.
// Results sit in an output register, so the block takes the next request while
// the final result of the previous one is still waiting.
module av_sync_audio_delay_queue import avsadq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [TS_W-1:0]       audio_ts,
	input  wire logic [FRAMES_W-1:0]   frame_count,
	input  wire logic [TAG_W-1:0]      packet_tag,
	input  wire logic [PAD_W-1:0]      pad_frames,
	input  wire logic [TS_W-1:0]       video_ts,
	input  wire logic [TS_W-1:0]       now_ns,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [ACT_W-1:0]           action,
	output logic [TAG_W-1:0]           out_tag,
	output logic [TS_W-1:0]            out_ts,
	output logic [FRAMES_W-1:0]        out_frames,
	output logic                       last,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int HEAD_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	// config
	logic [RATE_W-1:0]  dev_rate_q;
	logic [OFFS_W-1:0]  sync_offset_q;
	logic [WIN_W-1:0]   sync_window_q;
	logic [MAXD_W-1:0]  max_diff_q;
	logic [STALL_W-1:0] video_stall_q;
	logic [IDLE_W-1:0]  idle_flush_q;

	// queue ring
	logic [WIDE_W-1:0]   qts_q    [QUEUE_DEPTH];
	logic [FRAMES_W-1:0] qframes_q[QUEUE_DEPTH];
	logic [TAG_W-1:0]    qtag_q   [QUEUE_DEPTH];
	logic [HEAD_W-1:0]   head_q;
	logic [CNT_W-1:0]    count_q;

	// trackers
	logic [TS_W-1:0]   last_arrival_q;
	logic [TS_W-1:0]   prev_video_q;
	logic [WIDE_W-1:0] stall_q;

	// current request
	logic [TS_W-1:0]     a_ts_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [TAG_W-1:0]    tag_q;
	logic [PAD_W-1:0]    pad_q;
	logic [TS_W-1:0]     video_q;
	logic [TS_W-1:0]     now_q;
	logic [WIDE_W-1:0]   ts_q;       // offset timestamp
	logic [PROD_W-1:0]   pad_ns_q;
	logic [WIDE_W-1:0]   diff_q;
	logic [WIDE_W-1:0]   mag_q;
	logic                neg_q;

	// output register
	logic                out_valid_q;
	avsadq_action_t      out_action_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic [TS_W-1:0]     out_ts_q;
	logic [FRAMES_W-1:0] out_frames_q;
	logic                out_last_q;

	avsadq_state_t state_q, state_d;

	avsadq_div_req_t div_req;
	avsadq_div_rsp_t div_rsp;

	// sequencer controls
	logic                emit;
	avsadq_action_t      emit_action;
	logic [TAG_W-1:0]    emit_tag;
	logic [WIDE_W-1:0]   emit_ts;
	logic [FRAMES_W-1:0] emit_frames;
	logic                emit_last;
	logic                pop, push, head_clr;
	logic                out_free;

	logic [WIDE_W-1:0]   gap;
	logic                flush_due;
	logic [CNT_W:0]      slot_sum;
	logic [HEAD_W-1:0]   slot;
	logic [HEAD_W-1:0]   head_inc;
	logic                full;
	logic                bad, beyond;
	logic [WIDE_W:0]     stall_sum;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ready;

	assign gap       = WIDE_W'(now_q) - WIDE_W'(last_arrival_q);
	assign flush_due = gap > WIDE_W'(idle_flush_q);
	assign full      = count_q >= CNT_W'(QUEUE_DEPTH);

	// head + count stays below twice the depth: one compare and subtract
	assign slot_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
	assign slot     = (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH))
		? HEAD_W'(slot_sum - (CNT_W+1)'(QUEUE_DEPTH)) : HEAD_W'(slot_sum);
	assign head_inc = (head_q == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	// sync is ignored without video, with a wild difference or a stalled picture
	assign bad    = (video_q == '0) || (mag_q > WIDE_W'(max_diff_q))
		|| (stall_q > WIDE_W'(video_stall_q));
	assign beyond = mag_q > WIDE_W'(sync_window_q);

	assign stall_sum = {1'b0, stall_q} + (WIDE_W+1)'(div_rsp.quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		emit           = 1'b0;
		emit_action    = ACT_HOLD;
		emit_tag       = '0;
		emit_ts        = '0;
		emit_frames    = '0;
		emit_last      = 1'b0;
		pop            = 1'b0;
		push           = 1'b0;
		head_clr       = 1'b0;
		div_req.start  = 1'b0;
		div_req.frames = PAD_W'(frames_q);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_GAP;
				end
			end
			ST_GAP: begin
				state_d = flush_due ? ST_FLUSH : ST_ENQ;
			end
			ST_FLUSH: begin
				if (count_q == '0) begin
					head_clr = 1'b1;
					state_d  = ST_ENQ;
				end else if (out_free) begin
					emit        = 1'b1;
					emit_action = ACT_FLUSH;
					emit_tag    = qtag_q[head_q];
					emit_ts     = qts_q[head_q];
					emit_frames = qframes_q[head_q];
					pop         = 1'b1;
				end
			end
			ST_ENQ: begin
				if (full) begin
					if (out_free) begin
						emit          = 1'b1;
						emit_action   = ACT_REJECT;
						emit_tag      = tag_q;
						emit_ts       = ts_q;
						emit_frames   = frames_q;
						div_req.start = 1'b1;
						state_d       = ST_DIV_F;
					end
				end else begin
					push          = 1'b1;
					div_req.start = 1'b1;
					state_d       = ST_DIV_F;
				end
			end
			ST_DIV_F: begin
				if (div_rsp.done) begin
					div_req.start  = 1'b1;
					div_req.frames = pad_q;
					state_d        = ST_DIV_P;
				end
			end
			ST_DIV_P: begin
				if (div_rsp.done) begin
					state_d = ST_WALK_DIFF;
				end
			end
			ST_WALK_DIFF: begin
				state_d = ST_WALK_MAG;
			end
			ST_WALK_MAG: begin
				state_d = ST_WALK_DEC;
			end
			ST_WALK_DEC: begin
				if (out_free) begin
					emit = 1'b1;
					if (count_q == '0 || (!bad && !neg_q && beyond)) begin
						emit_action = ACT_HOLD;
						emit_last   = 1'b1;
						state_d     = ST_IDLE;
					end else begin
						pop         = 1'b1;
						emit_tag    = qtag_q[head_q];
						emit_ts     = qts_q[head_q];
						emit_frames = qframes_q[head_q];
						if (!bad && neg_q && beyond && count_q > CNT_W'(1)) begin
							emit_action = ACT_DROP;
							state_d     = ST_WALK_DIFF;
						end else begin
							emit_action = ACT_PLAY;
							emit_last   = 1'b1;
							state_d     = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_rate_q     <= RST_DEV_RATE;
			sync_offset_q  <= RST_SYNC_OFFSET;
			sync_window_q  <= RST_SYNC_WINDOW;
			max_diff_q     <= RST_MAX_DIFF;
			video_stall_q  <= RST_VIDEO_STALL;
			idle_flush_q   <= RST_IDLE_FLUSH;
			head_q         <= '0;
			count_q        <= '0;
			last_arrival_q <= '0;
			prev_video_q   <= '0;
			stall_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_DEV_RATE:    dev_rate_q    <= cfg_data[RATE_W-1:0];
					CFG_SYNC_OFFSET: sync_offset_q <= cfg_data[OFFS_W-1:0];
					CFG_SYNC_WINDOW: sync_window_q <= cfg_data[WIN_W-1:0];
					CFG_MAX_DIFF:    max_diff_q    <= cfg_data[MAXD_W-1:0];
					CFG_VIDEO_STALL: video_stall_q <= cfg_data[STALL_W-1:0];
					CFG_IDLE_FLUSH:  idle_flush_q  <= cfg_data[IDLE_W-1:0];
					default: ;
				endcase
			end

			if (state_q == ST_GAP) begin
				last_arrival_q <= now_q;
			end

			if (head_clr) begin
				head_q <= '0;
			end else if (pop) begin
				head_q <= head_inc;
			end
			if (pop) begin
				count_q <= count_q - 1'b1;
			end else if (push) begin
				count_q <= count_q + 1'b1;
			end

			// video stall tracker, fed by the packet duration
			if (state_q == ST_DIV_F && div_rsp.done) begin
				if (prev_video_q == '0) begin
					prev_video_q <= video_q;
				end else if (prev_video_q == video_q) begin
					stall_q <= stall_sum[WIDE_W] ? '1 : stall_sum[WIDE_W-1:0];
				end else begin
					stall_q      <= '0;
					prev_video_q <= video_q;
				end
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			a_ts_q   <= audio_ts;
			frames_q <= frame_count;
			tag_q    <= packet_tag;
			pad_q    <= pad_frames;
			video_q  <= video_ts;
			now_q    <= now_ns;
		end
		if (state_q == ST_GAP) begin
			ts_q <= WIDE_W'(a_ts_q) + {{(WIDE_W-OFFS_W){sync_offset_q[OFFS_W-1]}}, sync_offset_q};
		end
		if (push) begin
			qts_q[slot]     <= ts_q;
			qframes_q[slot] <= frames_q;
			qtag_q[slot]    <= tag_q;
		end
		if (state_q == ST_DIV_P && div_rsp.done) begin
			pad_ns_q <= div_rsp.quo;
		end
		if (state_q == ST_WALK_DIFF) begin
			diff_q <= qts_q[head_q] - WIDE_W'(pad_ns_q) - WIDE_W'(video_q);
		end
		if (state_q == ST_WALK_MAG) begin
			neg_q <= diff_q[WIDE_W-1];
			mag_q <= diff_q[WIDE_W-1] ? (~diff_q + 1'b1) : diff_q;
		end
		if (emit) begin
			out_action_q <= emit_action;
			out_tag_q    <= emit_tag;
			out_ts_q     <= emit_ts[TS_W-1:0];
			out_frames_q <= emit_frames;
			out_last_q   <= emit_last;
		end
	end

	avsadq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.dev_rate (dev_rate_q),
		.req      (div_req),
		.rsp      (div_rsp)
	);

	assign out_valid  = out_valid_q;
	assign action     = out_action_q;
	assign out_tag    = out_tag_q;
	assign out_ts     = out_ts_q;
	assign out_frames = out_frames_q;
	assign last       = out_last_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_drop_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_action_q == ACT_DROP) |-> !out_last_q)
		else $error("drop marked as final result");

	a_flush_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && state_d == ST_ENQ) |=> (head_q == '0 && count_q <= CNT_W'(1)))
		else $error("flush left queue in use");

	a_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_action_q == ACT_HOLD) |-> (out_tag_q == '0 && out_last_q))
		else $error("hold result carries a tag or is not final");

endmodule

`default_nettype wire
